[sv/rfss_pkg.sv]
// shared types, codes, constants and ease table builders for the soft-start ramp
`timescale 1ns / 1ps

package rfss_pkg;

    localparam int FREQ_W     = 20;
    localparam int DUR_W      = 16;
    localparam int DUTY_W     = 10;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;
    localparam int ACC_W      = 40;
    localparam int MUL_A_W    = 22;
    localparam int MUL_B_W    = 18;
    localparam int Q_W        = 16;
    localparam int WGT_W      = 17;

    // operation codes
    localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_TARGET = 3'd2;
    localparam logic [OP_W-1:0] OP_PAUSE  = 3'd3;
    localparam logic [OP_W-1:0] OP_RESUME = 3'd4;
    localparam logic [OP_W-1:0] OP_ABORT  = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_FREQ    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FREQ      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_FREQ      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_FREQ = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_DURATION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EASE_MODE     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_DUTY      = 3'd6;

    // register reset values
    localparam logic [FREQ_W-1:0] START_FREQ_RST    = 20'd250000;
    localparam logic [FREQ_W-1:0] MIN_FREQ_RST      = 20'd50000;
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST      = 20'd300000;
    localparam logic [FREQ_W-1:0] FAILSAFE_FREQ_RST = 20'd0;
    localparam logic [DUR_W-1:0]  RAMP_DURATION_RST = 16'd100;
    localparam logic              EASE_MODE_RST     = 1'b1;
    localparam logic [DUTY_W-1:0] PWM_DUTY_RST      = 10'd500;

    localparam logic [DUTY_W-1:0] DUTY_MAX    = 10'd1000;
    localparam logic [DUR_W-1:0]  ELAPSED_SAT = 16'hFFFF;
    localparam logic [WGT_W-1:0]  WEIGHT_ONE  = 17'h10000;

    // shared unit operations
    localparam logic [2:0] ALU_HOLD = 3'd0;
    localparam logic [2:0] ALU_LOAD = 3'd1;
    localparam logic [2:0] ALU_DIV  = 3'd2;
    localparam logic [2:0] ALU_MUL  = 3'd3;
    localparam logic [2:0] ALU_MAC  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [FREQ_W-1:0] target_freq;
        logic              fault;
    } in_word_t;

    typedef struct packed {
        logic [FREQ_W-1:0] freq_hz;
        logic [DUTY_W-1:0] duty;
        logic              ramp_active;
        logic              ramp_paused;
    } out_word_t;

    typedef struct packed {
        logic [2:0]                 op;
        logic [DUR_W-1:0]           load_val;
        logic signed [MUL_A_W-1:0]  mul_a;
        logic signed [MUL_B_W-1:0]  mul_b;
    } alu_cmd_t;

    // when the limits cross, x below the lower limit gives the lower limit, any other x the upper
    function automatic logic [FREQ_W-1:0] clamp_freq(input logic [FREQ_W-1:0] x,
                                                     input logic [FREQ_W-1:0] lo,
                                                     input logic [FREQ_W-1:0] hi);
        if (x < lo) return lo;
        if (x > hi) return hi;
        return x;
    endfunction

    localparam logic [FREQ_W-1:0] FREQ_RST =
        clamp_freq(START_FREQ_RST, MIN_FREQ_RST, MAX_FREQ_RST);

    // ---- elaboration-time table builders ----

    localparam logic [63:0] ONE_Q24 = 64'd1 << 24;
    localparam logic [63:0] ONE_Q28 = 64'd1 << 28;
    localparam logic [63:0] PI_Q28  = 64'd843314857;

    // long division by shift and subtract
    function automatic logic [63:0] div64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[62:0], num[k]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^y, y and result in Q24
    function automatic logic [63:0] exp_q24(input logic [63:0] y);
        logic [63:0] sum;
        logic [63:0] term;
        logic        done;
        sum  = ONE_Q24;
        term = ONE_Q24;
        done = 1'b0;
        for (int n = 1; n < 100; n++) begin
            if (!done) begin
                term = div64(term * y, 64'(n) << 24);
                if (term == 64'd0) done = 1'b1;
                else sum = sum + term;
            end
        end
        return sum;
    endfunction

    // 0.5*(1-cos(x)), x in Q28, result in Q16
    function automatic logic [15:0] cos_weight(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        w;
        logic signed [63:0] sum;
        logic signed [63:0] d;
        logic               done;
        x2   = (x * x) >> 28;
        term = ONE_Q28;
        sum  = $signed(ONE_Q28);
        done = 1'b0;
        for (int n = 1; n < 40; n++) begin
            if (!done) begin
                term = div64(term * x2, ONE_Q28 * 64'((2 * n - 1) * (2 * n)));
                if (term == 64'd0) done = 1'b1;
                else if (n % 2 == 1) sum = sum - $signed(term);
                else sum = sum + $signed(term);
            end
        end
        d = $signed(ONE_Q28) - sum;
        if (d < 0) d = '0;
        w = ($unsigned(d) + 64'd4096) >> 13;
        return (w > 64'd65535) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [15:0] ease_entry(input logic is_cos, input int unsigned i,
                                               input int unsigned depth,
                                               input int unsigned shape);
        logic [63:0] ak;
        logic [63:0] den;
        logic [63:0] y;
        logic [63:0] ay;
        logic [63:0] num;
        logic [63:0] w;
        if (is_cos) return cos_weight(div64(PI_Q28 * 64'(i), 64'(depth)));
        ak  = div64(64'd1 << 56, exp_q24(64'(shape) << 24));
        den = (64'd1 << 32) - ak;
        y   = div64(64'(shape) * ONE_Q24 * 64'(i), 64'(depth));
        ay  = div64(64'd1 << 56, exp_q24(y));
        num = (ay >= (64'd1 << 32)) ? 64'd0 : (64'd1 << 32) - ay;
        w   = div64(num * 64'd65536 + (den >> 1), den);
        return (w > 64'd65535) ? 16'hFFFF : w[15:0];
    endfunction

endpackage

[sv/rfss_rom.sv]
// constant ease curve tables, exponential and raised cosine, registered read
`timescale 1ns / 1ps

module rfss_rom
    import rfss_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int SHAPE = 3
)
(
    input  logic                     clk,
    input  logic                     mode,
    input  logic [$clog2(DEPTH)-1:0] addr,
    output logic [15:0]              data
);

    logic [15:0] exp_tbl [DEPTH];
    logic [15:0] cos_tbl [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_entry
        localparam logic [15:0] EXP_VAL = ease_entry(1'b0, g, DEPTH, SHAPE);
        localparam logic [15:0] COS_VAL = ease_entry(1'b1, g, DEPTH, SHAPE);
        assign exp_tbl[g] = EXP_VAL;
        assign cos_tbl[g] = COS_VAL;
    end

    always_ff @(posedge clk)
    begin
        data <= mode ? cos_tbl[addr] : exp_tbl[addr];
    end

endmodule

[sv/rfss_alu.sv]
// shared arithmetic unit: divide step, multiply and multiply-accumulate
`timescale 1ns / 1ps

module rfss_alu
    import rfss_pkg::*;
(
    input  logic                     clk,
    input  alu_cmd_t                 cmd,
    input  logic [DUR_W-1:0]         divisor,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] prod;
    logic [DUR_W:0]          rem_shift;
    logic                    rem_ge;
    logic [DUR_W:0]          rem_new;

    // remainder lives in [32:16], quotient shifts in at [15:0]
    assign prod      = cmd.mul_a * cmd.mul_b;
    assign rem_shift = {acc_reg[Q_W+DUR_W-1:Q_W], 1'b0};
    assign rem_ge    = rem_shift >= {1'b0, divisor};
    assign rem_new   = rem_ge ? rem_shift - {1'b0, divisor} : rem_shift;

    always_comb
    begin
        acc_next = acc_reg;
        case (cmd.op)
            ALU_LOAD: acc_next = {8'd0, cmd.load_val, 16'd0};
            ALU_DIV:  acc_next = {7'd0, rem_new, acc_reg[Q_W-2:0], rem_ge};
            ALU_MUL:  acc_next = prod;
            ALU_MAC:  acc_next = acc_reg + prod;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

[sv/resonant_freq_soft_start_ramp.sv]
// top level of the soft-start frequency ramp: sequencer, ramp state and config registers
//
// usage:
//   input channel (in_valid/in_ready/in_data) takes one command word: tick, start,
//   update target, pause, resume or abort. output channel (out_valid/out_ready/
//   out_data) gives one word with frequency, duty and flags for every command that
//   applies a frequency; update target, pause, resume, an idle tick and unused codes
//   give no word and leave the block ready in the next cycle.
//   config port: cfg_wr_en writes cfg_data into register cfg_index, single cycle; the user
//   must write only while the block is idle; the block itself has no check for it.
// sequencing:
//   start, abort, fault tick, held tick and the tick that ends the ramp go to the
//   output step, which registers the word and raises out_valid; the next command
//   is taken back in idle. an interpolating tick runs 16 restoring division steps
//   on the shared unit, index, table read wait, two interpolation multiply steps,
//   blend multiply, sum and output step, all multiplies on the same multiplier.
//   a stall holds the output step. in_ready is low while a command is in work.
// reset: flags and elapsed count clear, start/target/last frequency load the clamped
//   start frequency, config registers load their defaults; the curve tables are
//   constants and need no fill.
// stall: a finished word waits in the output register; the block takes the next
//   command meanwhile and only its own result waits for the register to free up.
`timescale 1ns / 1ps

module resonant_freq_soft_start_ramp
    import rfss_pkg::*;
#(
    parameter int EASE_TABLE_DEPTH = 256,
    parameter int EXP_SHAPE        = 3
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_word_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_word_t             out_data
);

    localparam int IDX_W    = $clog2(EASE_TABLE_DEPTH);
    localparam int SCALED_W = Q_W + IDX_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(EASE_TABLE_DEPTH - 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DIV   = 4'd1;
    localparam logic [3:0] S_IDX   = 4'd2;
    localparam logic [3:0] S_RDA   = 4'd3;
    localparam logic [3:0] S_RDB   = 4'd4;
    localparam logic [3:0] S_MACB  = 4'd5;
    localparam logic [3:0] S_BLEND = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_APPLY = 4'd8;

    // config registers
    logic [FREQ_W-1:0] start_freq_reg;
    logic [FREQ_W-1:0] min_freq_reg;
    logic [FREQ_W-1:0] max_freq_reg;
    logic [FREQ_W-1:0] failsafe_freq_reg;
    logic [DUR_W-1:0]  ramp_duration_reg;
    logic              ease_mode_reg;
    logic [DUTY_W-1:0] pwm_duty_reg;

    // control and ramp state
    logic [3:0]        state_reg,   state_next;
    logic              on_reg,      on_next;
    logic              hold_reg,    hold_next;
    logic [DUR_W-1:0]  elapsed_reg, elapsed_next;
    logic [FREQ_W-1:0] from_reg,    from_next;
    logic [FREQ_W-1:0] to_reg,      to_next;
    logic [FREQ_W-1:0] last_reg,    last_next;
    logic [3:0]        cnt_reg,     cnt_next;
    logic              out_valid_reg, out_valid_next;

    // payload
    logic [FREQ_W-1:0] src_reg,  src_next;
    logic [IDX_W-1:0]  idx_reg,  idx_next;
    logic [Q_W-1:0]    frac_reg, frac_next;
    out_word_t         out_data_reg, out_data_next;

    alu_cmd_t                alu_cmd;
    logic signed [ACC_W-1:0] acc;
    logic [15:0]             rom_q;
    logic [IDX_W-1:0]        rom_addr;

    logic                    in_fire;
    logic [DUR_W-1:0]        elapsed_inc;
    logic [FREQ_W-1:0]       from_c;
    logic [FREQ_W-1:0]       to_c;
    logic [SCALED_W-1:0]     scaled;
    logic                    idx_is_last;
    logic [WGT_W-1:0]        one_minus_frac;
    logic [WGT_W-1:0]        b_sel;
    logic [WGT_W-1:0]        weight;
    logic signed [FREQ_W:0]  diff;
    logic signed [ACC_W-1:0] delta_full;
    logic [FREQ_W:0]         blend_sum;
    logic [DUTY_W-1:0]       duty_sat;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_freq_reg    <= START_FREQ_RST;
            min_freq_reg      <= MIN_FREQ_RST;
            max_freq_reg      <= MAX_FREQ_RST;
            failsafe_freq_reg <= FAILSAFE_FREQ_RST;
            ramp_duration_reg <= RAMP_DURATION_RST;
            ease_mode_reg     <= EASE_MODE_RST;
            pwm_duty_reg      <= PWM_DUTY_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_START_FREQ:    start_freq_reg    <= cfg_data[FREQ_W-1:0];
                REG_MIN_FREQ:      min_freq_reg      <= cfg_data[FREQ_W-1:0];
                REG_MAX_FREQ:      max_freq_reg      <= cfg_data[FREQ_W-1:0];
                REG_FAILSAFE_FREQ: failsafe_freq_reg <= cfg_data[FREQ_W-1:0];
                REG_RAMP_DURATION: ramp_duration_reg <= cfg_data[DUR_W-1:0];
                REG_EASE_MODE:     ease_mode_reg     <= cfg_data[0];
                REG_PWM_DUTY:      pwm_duty_reg      <= cfg_data[DUTY_W-1:0];
                default: ;
            endcase
        end
    end

    // shared arithmetic unit and curve table
    rfss_alu u_alu (
        .clk     (clk),
        .cmd     (alu_cmd),
        .divisor (ramp_duration_reg),
        .acc     (acc)
    );

    rfss_rom #(
        .DEPTH (EASE_TABLE_DEPTH),
        .SHAPE (EXP_SHAPE)
    ) u_rom (
        .clk  (clk),
        .mode (ease_mode_reg),
        .addr (rom_addr),
        .data (rom_q)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;

    assign elapsed_inc = (elapsed_reg != ELAPSED_SAT) ? elapsed_reg + 1'b1 : elapsed_reg;
    assign from_c      = clamp_freq(start_freq_reg, min_freq_reg, max_freq_reg);
    assign to_c        = clamp_freq(in_data.target_freq, min_freq_reg, max_freq_reg);
    assign duty_sat    = (pwm_duty_reg > DUTY_MAX) ? DUTY_MAX : pwm_duty_reg;

    // progress in q16 times table depth: upper bits index, lower bits fraction
    assign scaled = SCALED_W'(acc[Q_W-1:0]) * SCALED_W'(EASE_TABLE_DEPTH);

    // entry after the top one reads as 1.0
    assign idx_is_last    = (idx_reg == IDX_LAST);
    assign rom_addr       = (state_reg == S_RDB && !idx_is_last) ? idx_reg + 1'b1 : idx_reg;
    assign one_minus_frac = WEIGHT_ONE - {1'b0, frac_reg};
    assign b_sel          = idx_is_last ? WEIGHT_ONE : {1'b0, rom_q};
    assign weight         = acc[Q_W+WGT_W-1:Q_W];

    // signed span of the ramp; arithmetic shift floors both signs
    assign diff       = $signed({1'b0, to_reg}) - $signed({1'b0, from_reg});
    assign delta_full = acc >>> Q_W;
    assign blend_sum  = {1'b0, from_reg} + delta_full[FREQ_W:0];

    always_comb
    begin
        state_next     = state_reg;
        on_next        = on_reg;
        hold_next      = hold_reg;
        elapsed_next   = elapsed_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        src_next       = src_reg;
        idx_next       = idx_reg;
        frac_next      = frac_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        alu_cmd        = '{op: ALU_HOLD, load_val: '0, mul_a: '0, mul_b: '0};

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.operation)
                        OP_TICK:
                        begin
                            if (on_reg)
                            begin
                                if (in_data.fault)
                                begin
                                    // fault acts as abort
                                    on_next    = 1'b0;
                                    hold_next  = 1'b0;
                                    src_next   = failsafe_freq_reg;
                                    state_next = S_APPLY;
                                end
                                else if (hold_reg)
                                begin
                                    src_next   = last_reg;
                                    state_next = S_APPLY;
                                end
                                else
                                begin
                                    elapsed_next = elapsed_inc;
                                    if (elapsed_inc >= ramp_duration_reg)
                                    begin
                                        // ramp done, land on target
                                        on_next    = 1'b0;
                                        src_next   = to_reg;
                                        state_next = S_APPLY;
                                    end
                                    else
                                    begin
                                        alu_cmd.op       = ALU_LOAD;
                                        alu_cmd.load_val = elapsed_inc;
                                        cnt_next         = '0;
                                        state_next       = S_DIV;
                                    end
                                end
                            end
                        end
                        OP_START:
                        begin
                            hold_next    = 1'b0;
                            elapsed_next = '0;
                            from_next    = from_c;
                            to_next      = to_c;
                            if (ramp_duration_reg == '0 || from_c == to_c)
                            begin
                                on_next  = 1'b0;
                                src_next = to_c;
                            end
                            else
                            begin
                                on_next  = 1'b1;
                                src_next = from_c;
                            end
                            state_next = S_APPLY;
                        end
                        OP_TARGET: to_next   = to_c;
                        OP_PAUSE:  hold_next = 1'b1;
                        OP_RESUME: hold_next = 1'b0;
                        OP_ABORT:
                        begin
                            on_next    = 1'b0;
                            hold_next  = 1'b0;
                            src_next   = failsafe_freq_reg;
                            state_next = S_APPLY;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV:
            begin
                alu_cmd.op = ALU_DIV;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == 4'd15)
                    state_next = S_IDX;
            end
            S_IDX:
            begin
                idx_next   = scaled[SCALED_W-1:Q_W];
                frac_next  = scaled[Q_W-1:0];
                state_next = S_RDA;
            end
            S_RDA:
            begin
                state_next = S_RDB;
            end
            S_RDB:
            begin
                // lower entry weighted by 1 - frac
                alu_cmd.op    = ALU_MUL;
                alu_cmd.mul_a = {6'd0, rom_q};
                alu_cmd.mul_b = {1'b0, one_minus_frac};
                state_next    = S_MACB;
            end
            S_MACB:
            begin
                alu_cmd.op    = ALU_MAC;
                alu_cmd.mul_a = {5'd0, b_sel};
                alu_cmd.mul_b = {2'd0, frac_reg};
                state_next    = S_BLEND;
            end
            S_BLEND:
            begin
                alu_cmd.op    = ALU_MUL;
                alu_cmd.mul_a = {diff[FREQ_W], diff};
                alu_cmd.mul_b = {1'b0, weight};
                state_next    = S_SUM;
            end
            S_SUM:
            begin
                src_next   = blend_sum[FREQ_W-1:0];
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    last_next                 = clamp_freq(src_reg, min_freq_reg, max_freq_reg);
                    out_data_next.freq_hz     = last_next;
                    out_data_next.duty        = duty_sat;
                    out_data_next.ramp_active = on_reg;
                    out_data_next.ramp_paused = hold_reg;
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            on_reg        <= 1'b0;
            hold_reg      <= 1'b0;
            elapsed_reg   <= '0;
            from_reg      <= FREQ_RST;
            to_reg        <= FREQ_RST;
            last_reg      <= FREQ_RST;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            on_reg        <= on_next;
            hold_reg      <= hold_next;
            elapsed_reg   <= elapsed_next;
            from_reg      <= from_next;
            to_reg        <= to_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg      <= src_next;
        idx_reg      <= idx_next;
        frac_reg     <= frac_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/rfss_checker.sv]
// port-level checks for the soft-start ramp, bound to the top level
`timescale 1ns / 1ps

module rfss_checker
    import rfss_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_word_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output word changed while stalled");

    a_duty_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.duty <= DUTY_MAX)
        else $error("duty above saturation limit");

    // a held ramp is always a running ramp
    a_pause_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.ramp_paused |-> out_data.ramp_active)
        else $error("paused flag without active ramp");

    a_abort_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.operation == OP_ABORT |=> !in_ready)
        else $error("abort did not occupy the block");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.operation == OP_START |=> !in_ready)
        else $error("start did not occupy the block");

endmodule

bind resonant_freq_soft_start_ramp rfss_checker u_rfss_checker (.*);
